// ===== src/mhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and constants for the binary max-heap priority queue: word
// formats of both channels, heap entry layout, memory request and the
// status handed from the sequencer to the top level.
// ----------------------------------------------------------------------------
package mhpq_pkg;

	localparam int CAPACITY  = 64;
	localparam int PAYLOAD_W = 32;
	localparam int PRIO_W    = 16;
	localparam int ADDR_W    = $clog2(CAPACITY);
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int CHILD_W   = ADDR_W + 2;
	localparam int ENTRY_W   = PAYLOAD_W + PRIO_W;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [PAYLOAD_W-1:0]      payload;
		logic signed [PRIO_W-1:0]  prio;
	} entry_t;

	typedef struct packed {
		logic                      opcode;
		logic [PAYLOAD_W-1:0]      payload;
		logic signed [PRIO_W-1:0]  prio;
	} cmd_word_t;

	typedef struct packed {
		logic [PAYLOAD_W-1:0]      top_payload;
		logic signed [PRIO_W-1:0]  top_prio;
		logic                      is_empty;
		logic [CNT_W-1:0]          entry_total;
		logic [1:0]                status;
	} rsp_word_t;

	typedef struct packed {
		logic                we;
		logic [ADDR_W-1:0]   waddr;
		logic [ENTRY_W-1:0]  wdata;
		logic [ADDR_W-1:0]   raddr;
	} mem_req_t;

	typedef struct packed {
		logic              busy;
		logic              fire;
		logic [1:0]        status;
		logic [CNT_W-1:0]  count;
	} seq_stat_t;

endpackage

// ===== src/mhpq_ram.sv =====
// ----------------------------------------------------------------------------
// mhpq_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module mhpq_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [$clog2(DEPTH)-1:0]  waddr,
	input  logic [WIDTH-1:0]          wdata,
	input  logic [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/mhpq_seq.sv =====
// ----------------------------------------------------------------------------
// mhpq_seq
// Heap sequencer: walks sift-up and sift-down over the heap memory with a
// moving hole, one read port and one write port.
// ----------------------------------------------------------------------------
module mhpq_seq import mhpq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  cmd_word_t          cmd,
	input  logic               res_free,
	input  logic [ENTRY_W-1:0] rdata,
	output mem_req_t           mem_req,
	output seq_stat_t          stat
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_UP_RD    = 4'd1;
	localparam logic [3:0] S_UP_CMP   = 4'd2;
	localparam logic [3:0] S_UP_PUT   = 4'd3;
	localparam logic [3:0] S_DN_LAST  = 4'd4;
	localparam logic [3:0] S_DN_LOAD  = 4'd5;
	localparam logic [3:0] S_DN_LEFT  = 4'd6;
	localparam logic [3:0] S_DN_RIGHT = 4'd7;
	localparam logic [3:0] S_DN_CMP   = 4'd8;
	localparam logic [3:0] S_FIN_RD   = 4'd9;
	localparam logic [3:0] S_FIN_WAIT = 4'd10;

	logic [3:0]         state_q, state_d;
	logic [CNT_W-1:0]   fill_q, fill_d;
	logic [ADDR_W-1:0]  idx_q, idx_d;
	entry_t             cur_q, cur_d;
	entry_t             lch_q, lch_d;
	logic               r_ok_q, r_ok_d;
	logic [1:0]         status_q, status_d;

	entry_t             rd_e;
	entry_t             cmd_e;
	logic [ADDR_W-1:0]  parent;
	logic [ADDR_W-1:0]  grand;
	logic [CHILD_W-1:0] lidx;
	logic [CHILD_W-1:0] ridx;
	logic [CHILD_W-1:0] fill_ext;
	logic               l_win;
	logic               r_win;
	logic signed [PRIO_W-1:0] best_prio;

	assign rd_e          = entry_t'(rdata);
	assign cmd_e.payload = cmd.payload;
	assign cmd_e.prio    = cmd.prio;

	assign parent    = (idx_q - ADDR_W'(1)) >> 1;
	assign grand     = (parent - ADDR_W'(1)) >> 1;
	assign lidx      = {1'b0, idx_q, 1'b1};
	assign ridx      = {1'b0, idx_q, 1'b0} + CHILD_W'(2);
	assign fill_ext  = CHILD_W'(fill_q);
	assign l_win     = lch_q.prio > cur_q.prio;
	assign best_prio = l_win ? lch_q.prio : cur_q.prio;
	assign r_win     = r_ok_q && (rd_e.prio > best_prio);

	always_comb begin
		state_d  = state_q;
		fill_d   = fill_q;
		idx_d    = idx_q;
		cur_d    = cur_q;
		lch_d    = lch_q;
		r_ok_d   = r_ok_q;
		status_d = status_q;
		mem_req  = '0;
		stat     = '0;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					status_d = ST_DONE;
					if (cmd.opcode == OP_PUSH) begin
						if (fill_q == CNT_W'(CAPACITY)) begin
							status_d = ST_FULL;
							state_d  = S_FIN_RD;
						end else begin
							cur_d   = cmd_e;
							idx_d   = fill_q[ADDR_W-1:0];
							fill_d  = fill_q + CNT_W'(1);
							state_d = (fill_q == '0) ? S_UP_PUT : S_UP_RD;
						end
					end else begin
						if (fill_q == '0) begin
							status_d = ST_EMPTY;
							state_d  = S_FIN_RD;
						end else begin
							fill_d  = fill_q - CNT_W'(1);
							idx_d   = '0;
							state_d = (fill_q == CNT_W'(1)) ? S_FIN_RD : S_DN_LAST;
						end
					end
				end
			end
			S_UP_RD: begin
				mem_req.raddr = parent;
				state_d       = S_UP_CMP;
			end
			S_UP_CMP: begin
				// move the parent down into the hole while the new entry wins
				mem_req.we = 1'b1;
				if (cur_q.prio > rd_e.prio) begin
					mem_req.waddr = idx_q;
					mem_req.wdata = rdata;
					idx_d         = parent;
					mem_req.raddr = grand;
					state_d       = (parent == '0) ? S_UP_PUT : S_UP_CMP;
				end else begin
					mem_req.waddr = idx_q;
					mem_req.wdata = cur_q;
					state_d       = S_FIN_RD;
				end
			end
			S_UP_PUT: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = idx_q;
				mem_req.wdata = cur_q;
				state_d       = S_FIN_RD;
			end
			S_DN_LAST: begin
				mem_req.raddr = fill_q[ADDR_W-1:0];
				state_d       = S_DN_LOAD;
			end
			S_DN_LOAD: begin
				cur_d   = rd_e;
				state_d = S_DN_LEFT;
			end
			S_DN_LEFT: begin
				if (lidx >= fill_ext) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = idx_q;
					mem_req.wdata = cur_q;
					state_d       = S_FIN_RD;
				end else begin
					mem_req.raddr = lidx[ADDR_W-1:0];
					state_d       = S_DN_RIGHT;
				end
			end
			S_DN_RIGHT: begin
				lch_d         = rd_e;
				r_ok_d        = ridx < fill_ext;
				mem_req.raddr = ridx[ADDR_W-1:0];
				state_d       = S_DN_CMP;
			end
			S_DN_CMP: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = idx_q;
				if (r_win) begin
					mem_req.wdata = rdata;
					idx_d         = ridx[ADDR_W-1:0];
					state_d       = S_DN_LEFT;
				end else if (l_win) begin
					mem_req.wdata = lch_q;
					idx_d         = lidx[ADDR_W-1:0];
					state_d       = S_DN_LEFT;
				end else begin
					mem_req.wdata = cur_q;
					state_d       = S_FIN_RD;
				end
			end
			S_FIN_RD: begin
				state_d = S_FIN_WAIT;
			end
			S_FIN_WAIT: begin
				// root read keeps arriving while the result slot is full
				if (res_free) begin
					stat.fire = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		stat.busy   = state_q != S_IDLE;
		stat.status = status_q;
		stat.count  = fill_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fill_q   <= '0;
			status_q <= ST_DONE;
			r_ok_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			fill_q   <= fill_d;
			status_q <= status_d;
			r_ok_q   <= r_ok_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		cur_q <= cur_d;
		lch_q <= lch_d;
	end

endmodule

// ===== src/max_heap_priority_queue.sv =====
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap priority queue of 64 entries (32-bit payload, signed
// 16-bit priority) kept in one synchronous memory.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd): one word per operation,
//   opcode push or pop. A push stores payload with prio; a pop removes
//   the root. cmd_stall is high while an operation is in progress.
//   rsp channel (rsp_valid / rsp_stall / rsp): exactly one word per
//   command, giving the root, the count and a status (done, push
//   dropped because full, pop on empty) after the operation.
// Timing: one operation at a time. A push moves the parent down into
//   the hole for each level the entry climbs (at most 6), then writes
//   the entry; into an empty heap it writes the root directly. A pop
//   reads the last entry for the root's place and walks it down, at
//   most 5 levels. A dropped push, a pop on empty and a pop of the last
//   entry write no entry. The single memory read port sets the pace:
//   each sift-down level reads the left and right child in turn before
//   deciding. The next command is taken once the sequencer is idle again.
// Reset clears the count and the control; the memory is not cleared,
//   since only entries below the count are ever used.
// A stalled response holds in the output register; the finishing
//   operation waits until that register frees up.
// ----------------------------------------------------------------------------
module max_heap_priority_queue import mhpq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_word_t cmd,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_word_t rsp
);

	mem_req_t           mem_req;
	seq_stat_t          stat;
	logic [ENTRY_W-1:0] rdata;
	entry_t             root;
	logic               start;
	logic               res_free;
	logic               rsp_valid_q;
	rsp_word_t          rsp_q;

	// take a command only while the sequencer sits idle
	assign cmd_stall = stat.busy;
	assign start     = cmd_valid && !stat.busy;

	// result slot is free when empty or being drained this cycle
	assign res_free = !rsp_valid_q || !rsp_stall;
	assign root     = entry_t'(rdata);

	mhpq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (mem_req.we),
		.waddr(mem_req.waddr),
		.wdata(mem_req.wdata),
		.raddr(mem_req.raddr),
		.rdata(rdata)
	);

	mhpq_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.cmd     (cmd),
		.res_free(res_free),
		.rdata   (rdata),
		.mem_req (mem_req),
		.stat    (stat)
	);

	// response valid: set on completion, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (stat.fire) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// response payload: root as read back, zeroed when the heap is empty
	always_ff @(posedge clk) begin
		if (stat.fire) begin
			rsp_q.is_empty    <= stat.count == '0;
			rsp_q.entry_total <= stat.count;
			rsp_q.status      <= stat.status;
			if (stat.count == '0) begin
				rsp_q.top_payload <= '0;
				rsp_q.top_prio    <= '0;
			end else begin
				rsp_q.top_payload <= root.payload;
				rsp_q.top_prio    <= root.prio;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== tb/max_heap_priority_queue_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// max_heap_priority_queue_test
// Self-checking bench for the heap priority queue: a class keeps its own copy
// of the heap, works out the response word for every accepted command and
// checks the returned words against it in order, under random idling on both
// channels.
// ----------------------------------------------------------------------------

import mhpq_pkg::*;

class heap_scoreboard;
	entry_t    heap[CAPACITY];
	int        fill;
	rsp_word_t expected_replies[$];
	int        mismatches;
	int        checked;
	int        pushes;
	int        pops;
	int        full_drops;
	int        empty_pops;
	int        peak_fill;

	function new();
		fill       = 0;
		mismatches = 0;
		checked    = 0;
		pushes     = 0;
		pops       = 0;
		full_drops = 0;
		empty_pops = 0;
		peak_fill  = 0;
	endfunction

	function void swap_entries(int a, int b);
		entry_t t;
		t       = heap[a];
		heap[a] = heap[b];
		heap[b] = t;
	endfunction

	// Apply one command to the local heap and return the word it should answer.
	function rsp_word_t predict_heap_reply(cmd_word_t c);
		rsp_word_t r;
		int        i;
		int        up;
		int        lc;
		int        rc;
		int        best;
		r        = '0;
		r.status = ST_DONE;
		if (c.opcode == OP_PUSH) begin
			if (fill >= CAPACITY) begin
				r.status = ST_FULL;
				full_drops++;
			end else begin
				heap[fill].payload = c.payload;
				heap[fill].prio    = c.prio;
				i = fill;
				fill++;
				pushes++;
				if (fill > peak_fill) begin
					peak_fill = fill;
				end
				// climb while strictly above the parent; ties stay put
				while (i > 0) begin
					up = (i - 1) / 2;
					if ($signed(heap[i].prio) > $signed(heap[up].prio)) begin
						swap_entries(i, up);
						i = up;
					end else begin
						break;
					end
				end
			end
		end else begin
			if (fill == 0) begin
				r.status = ST_EMPTY;
				empty_pops++;
			end else begin
				heap[0] = heap[fill - 1];
				fill--;
				pops++;
				i = 0;
				// left child first, right only if strictly better than the best
				forever begin
					lc   = 2 * i + 1;
					rc   = 2 * i + 2;
					best = i;
					if (lc < fill && $signed(heap[lc].prio) > $signed(heap[best].prio)) begin
						best = lc;
					end
					if (rc < fill && $signed(heap[rc].prio) > $signed(heap[best].prio)) begin
						best = rc;
					end
					if (best == i) begin
						break;
					end
					swap_entries(i, best);
					i = best;
				end
			end
		end
		if (fill == 0) begin
			r.is_empty = 1'b1;
		end else begin
			r.top_payload = heap[0].payload;
			r.top_prio    = heap[0].prio;
		end
		r.entry_total = CNT_W'(fill);
		return r;
	endfunction

	function void note_command(cmd_word_t c);
		expected_replies.push_back(predict_heap_reply(c));
	endfunction

	task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		mismatches++;
		$display("%0t ns  mismatch %s: got %0h, expected %0h", $time, what, got, want);
	endtask

	task check_response(rsp_word_t got);
		rsp_word_t want;
		if (expected_replies.size() == 0) begin
			report_mismatch("response word with no command pending", got, '0);
			return;
		end
		want = expected_replies.pop_front();
		checked++;
		if (got.top_payload !== want.top_payload) begin
			report_mismatch("top_payload", got.top_payload, want.top_payload);
		end
		if (got.top_prio !== want.top_prio) begin
			report_mismatch("top_prio", got.top_prio, want.top_prio);
		end
		if (got.is_empty !== want.is_empty) begin
			report_mismatch("is_empty", got.is_empty, want.is_empty);
		end
		if (got.entry_total !== want.entry_total) begin
			report_mismatch("entry_total", got.entry_total, want.entry_total);
		end
		if (got.status !== want.status) begin
			report_mismatch("status", got.status, want.status);
		end
	endtask
endclass

module max_heap_priority_queue_test;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_stall;
	cmd_word_t cmd       = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_word_t rsp;

	// percent of cycles in which the command side holds back / the response
	// side stalls; changed per phase
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	heap_scoreboard sb;

	max_heap_priority_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Response side: check every word taken at this edge, then draw the
	// stall for the next cycle. Values read here are the ones before the edge.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			sb.check_response(rsp);
		end
		rsp_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	function automatic cmd_word_t make_cmd(logic op, logic [PAYLOAD_W-1:0] payload,
			logic signed [PRIO_W-1:0] prio);
		cmd_word_t w;
		w.opcode  = op;
		w.payload = payload;
		w.prio    = prio;
		return w;
	endfunction

	// Random command: push with the given odds, otherwise pop. Priorities
	// cluster in a narrow band part of the time so ties show up often.
	function automatic cmd_word_t random_cmd(int push_pct);
		cmd_word_t w;
		int        pick;
		int        band;
		w.opcode  = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
		w.payload = $urandom();
		pick      = $urandom_range(99);
		if (pick < 30) begin
			band   = $urandom_range(8);
			w.prio = PRIO_W'(band - 4);
		end else if (pick < 40) begin
			case ($urandom_range(3))
				0: w.prio = 16'sh8000;
				1: w.prio = 16'sh7fff;
				2: w.prio = 16'sh0000;
				default: w.prio = 16'shffff;
			endcase
		end else begin
			w.prio = PRIO_W'($urandom());
		end
		return w;
	endfunction

	// Offer one command word after a random hold-off, hold it until taken,
	// then let the scoreboard predict its response.
	task automatic send_cmd(input cmd_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= w;
		@(posedge clk);
		while (cmd_stall) begin
			@(posedge clk);
		end
		sb.note_command(w);
	endtask

	// Hand-picked opening: empty pops, extreme fields, ties at the root and
	// deeper down, drain back to empty.
	task automatic run_directed();
		send_cmd(make_cmd(OP_POP,  32'h0000_0000, 16'sh0000));
		send_cmd(make_cmd(OP_PUSH, 32'h0000_0000, 16'sh0000));
		send_cmd(make_cmd(OP_PUSH, 32'hffff_ffff, 16'sh7fff));
		send_cmd(make_cmd(OP_PUSH, 32'h0000_0001, 16'sh8000));
		send_cmd(make_cmd(OP_PUSH, 32'ha5a5_a5a5, 16'sh7fff));
		send_cmd(make_cmd(OP_PUSH, 32'h5a5a_5a5a, 16'shffff));
		send_cmd(make_cmd(OP_PUSH, 32'h1234_5678, 16'sh0000));
		send_cmd(make_cmd(OP_PUSH, 32'hc0de_0001, 16'sh7ffe));
		repeat (7) begin
			send_cmd(make_cmd(OP_POP, 32'hdead_beef, 16'sh1234));
		end
		send_cmd(make_cmd(OP_POP,  32'hffff_ffff, 16'shffff));
		send_cmd(make_cmd(OP_PUSH, 32'h8000_0000, 16'sh8000));
		send_cmd(make_cmd(OP_PUSH, 32'h7fff_ffff, 16'sh8000));
		send_cmd(make_cmd(OP_POP,  32'h0000_0000, 16'sh0000));
		send_cmd(make_cmd(OP_POP,  32'h0000_0000, 16'sh0000));
	endtask

	// Bursts that lean toward filling, draining or neither, so the heap
	// swings between empty and full over a phase.
	task automatic run_random_phase(int idle_pct, int stall_pct, int count);
		int sent;
		int burst;
		int push_pct;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < count) begin
			case ($urandom_range(2))
				0: push_pct = 85;
				1: push_pct = 15;
				default: push_pct = 55;
			endcase
			burst = $urandom_range(40, 140);
			for (int k = 0; k < burst && sent < count; k++) begin
				send_cmd(random_cmd(push_pct));
				sent++;
			end
		end
	endtask

	initial begin
		sb = new();
		// hold reset low, then release it on a clock edge
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		run_random_phase(14, 76, 333);
		run_random_phase(76, 14, 333);
		run_random_phase(0, 0, 334);
		cmd_valid <= 1'b0;

		// drain outstanding responses, then watch for stray words
		while (sb.expected_replies.size() != 0) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);

		$display("Ran %0d pushes and %0d pops, %0d pushes dropped on a full heap, %0d pops of an empty heap, peak fill %0d.",
			sb.pushes, sb.pops, sb.full_drops, sb.empty_pops, sb.peak_fill);
		$display("Checked %0d response words with %0d mismatches.", sb.checked, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("max_heap_priority_queue_test: PASS");
		end else begin
			$display("max_heap_priority_queue_test: FAIL");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#6_000_000;
		$display("max_heap_priority_queue_test: FAIL");
		$finish;
	end

endmodule
